FILE: hdl/sha256_pkg.sv
// Shared types and constants for the streaming SHA-256 hasher.
// Holds opcodes, command and status types, round constants, initial hash values and a rotate helper.
// No dependencies.
`default_nettype none
package sha256_pkg;

   localparam int unsigned WordWidth = 32;

   typedef enum logic [1:0] {
      OP_ABSORB        = 2'd0,
      OP_ABSORB_FINISH = 2'd1,
      OP_FINISH        = 2'd2,
      OP_NONE          = 2'd3
   } opcode_type;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [1:0] {
      SRC_MSG  = 2'd0,
      SRC_ZERO = 2'd1,
      SRC_PAD  = 2'd2,
      SRC_LEN  = 2'd3
   } src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_byte;
      logic [5:0] byte_addr;
      logic [7:0] byte_data;
      logic       count_byte;
      logic       start_rounds;
      logic       round_step;
      logic [5:0] round_idx;
      logic       fold;
      logic       reset_state;
      logic [2:0] out_idx;
      logic       load_w;
      src_type    w_src;
      logic [3:0] w_slot;
      logic [1:0] pad_lane;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [5:0] fill;
      word_type   out_word;
   } dp_status_type;

   localparam word_type InitH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam word_type RoundK [64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
      32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
      32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
      32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
      32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
      32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
      32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
      32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
      32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
      32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
      32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
      32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
      32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
   };

   function automatic word_type ror(input word_type x, input int unsigned n);
      ror = (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sha256_stream_if.sv
// Valid/ready stream interface used by the request and response channels.
// Payload type is a parameter. No dependencies.
`default_nettype none
interface sha256_stream_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/sha256_datapath.sv
// Datapath: block buffer memory, message schedule, round registers,
// chaining state and bit counter. Depends on sha256_pkg.
`default_nettype none
module sha256_datapath
   import sha256_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   output dp_status_type      status
);

   logic [7:0]  buf_mem [64];
   logic [31:0] rd_word_ff;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   word_type    new_w, t1, t2, wi, wsrc, pad_word;

   // The buffer is read one byte per cycle into a word shifter.
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         buf_mem[cmd.byte_addr] <= cmd.byte_data;
      end
      rd_word_ff <= {rd_word_ff[23:0], buf_mem[cmd.byte_addr]};
   end

   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.count_byte) begin
         fill_in = fill_ff + 6'd1;
         bits_in = bits_ff + 64'd8;
      end
      if (cmd.reset_state) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
      end
   end

   always_comb begin
      case (cmd.pad_lane)
         2'd0:    pad_word = 32'h8000_0000;
         2'd1:    pad_word = {rd_word_ff[31:24], 24'h80_0000};
         2'd2:    pad_word = {rd_word_ff[31:16], 16'h8000};
         default: pad_word = {rd_word_ff[31:8], 8'h80};
      endcase
   end

   always_comb begin
      unique case (cmd.w_src)
         SRC_MSG:  wsrc = rd_word_ff;
         SRC_ZERO: wsrc = '0;
         SRC_PAD:  wsrc = pad_word;
         SRC_LEN:  wsrc = (cmd.w_slot[0]) ? bits_ff[31:0] : bits_ff[63:32];
         default:  wsrc = '0;
      endcase
   end

   assign new_w = (ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10))
                + w_ff[9]
                + (ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3))
                + w_ff[0];
   assign wi = (cmd.round_idx < 6'd16) ? w_ff[cmd.round_idx[3:0]] : new_w;

   assign t1 = v_ff[7] + (ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + RoundK[cmd.round_idx] + wi;
   assign t2 = (ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_ff @(posedge clock) begin
      if (cmd.load_w) begin
         w_ff[cmd.w_slot] <= wsrc;
      end else if (cmd.round_step && cmd.round_idx >= 6'd16) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= new_w;
      end
      if (cmd.start_rounds) begin
         v_ff <= h_ff;
      end else if (cmd.round_step) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_state) begin
         h_ff <= InitH;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
   end

   assign status.fill     = fill_ff;
   assign status.out_word = h_ff[cmd.out_idx];

endmodule
`default_nettype wire

FILE: hdl/sha256_controller.sv
// Controller: sequences byte absorption, schedule loading, rounds,
// padding and digest output. Depends on sha256_pkg.
`default_nettype none
module sha256_controller
   import sha256_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire logic [1:0]    req_opcode,
   input  wire logic [7:0]    req_data_byte,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      logic [31:0]   rsp_digest_word,
   output      logic [2:0]    rsp_word_index,
   output      logic          rsp_last_word,
   output      ctrl_cmd_type  cmd,
   input  wire dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT, ST_CLEAR
   } state_type;

   state_type   state_ff;
   logic        finish_ff;
   logic        pad_ff;     // 0x80 already placed in a block
   logic        second_ff;  // padding needs one more block
   logic        final_ff;   // current block is the last one
   logic [5:0]  pos_ff;     // fill position at finish
   logic [6:0]  cnt_ff;
   logic [2:0]  oidx_ff;
   logic        ovalid_ff;
   logic        accept;
   opcode_type  op;
   logic [3:0]  slot;
   logic [1:0]  lane;
   logic [5:0]  next_fill;

   assign op        = opcode_type'(req_opcode);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot      = cnt_ff[5:2] - 4'd1;
   assign lane      = cnt_ff[1:0];
   assign next_fill = status.fill + 6'd1;

   // Command decode; word source: message, 0x80, zero or length.
   always_comb begin
      cmd = '0;
      cmd.out_idx   = oidx_ff;
      cmd.round_idx = cnt_ff[5:0];
      cmd.w_slot    = slot;
      cmd.w_src     = SRC_MSG;
      cmd.pad_lane  = pos_ff[1:0];
      if (accept && (op == OP_ABSORB || op == OP_ABSORB_FINISH)) begin
         cmd.load_byte  = 1'b1;
         cmd.byte_addr  = status.fill;
         cmd.byte_data  = req_data_byte;
         cmd.count_byte = 1'b1;
      end
      unique case (state_ff)
         ST_LOAD: begin
            cmd.byte_addr = cnt_ff[5:0];
            if (lane == 2'd0 && cnt_ff != 7'd0) begin
               cmd.load_w = 1'b1;
               if (finish_ff) begin
                  if (final_ff && slot >= 4'd14) begin
                     cmd.w_src = SRC_LEN;
                  end else if (pad_ff || slot > pos_ff[5:2]) begin
                     cmd.w_src = SRC_ZERO;
                  end else if (slot == pos_ff[5:2]) begin
                     cmd.w_src = SRC_PAD;
                  end
               end
            end
            if (cnt_ff == 7'd64) begin
               cmd.start_rounds = 1'b1;
            end
         end
         ST_ROUND: cmd.round_step = 1'b1;
         ST_FOLD:  cmd.fold = 1'b1;
         ST_CLEAR: cmd.reset_state = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         finish_ff <= 1'b0;
         pad_ff    <= 1'b0;
         second_ff <= 1'b0;
         final_ff  <= 1'b0;
         pos_ff    <= '0;
         cnt_ff    <= '0;
         oidx_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  if (op == OP_ABSORB) begin
                     if (status.fill == 6'd63) begin
                        finish_ff <= 1'b0;
                        final_ff  <= 1'b0;
                        state_ff  <= ST_LOAD;
                     end
                  end else if (op == OP_ABSORB_FINISH) begin
                     if (status.fill == 6'd63) begin
                        pad_ff    <= 1'b0;
                        final_ff  <= 1'b0;
                        finish_ff <= 1'b0;
                        pos_ff    <= '0;
                        state_ff  <= ST_LOAD;
                        // Plain block first, then a padding-only block.
                        second_ff <= 1'b1;
                     end else begin
                        finish_ff <= 1'b1;
                        pos_ff    <= next_fill;
                        pad_ff    <= 1'b0;
                        second_ff <= (next_fill > 6'd55);
                        final_ff  <= !(next_fill > 6'd55);
                        state_ff  <= ST_LOAD;
                     end
                  end else if (op == OP_FINISH) begin
                     finish_ff <= 1'b1;
                     pos_ff    <= status.fill;
                     pad_ff    <= 1'b0;
                     second_ff <= (status.fill > 6'd55);
                     final_ff  <= !(status.fill > 6'd55);
                     state_ff  <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               if (cnt_ff == 7'd64) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_ROUND;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_ROUND: begin
               if (cnt_ff == 7'd63) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_FOLD;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_FOLD: begin
               if (final_ff) begin
                  oidx_ff   <= '0;
                  ovalid_ff <= 1'b1;
                  state_ff  <= ST_OUT;
               end else if (finish_ff) begin
                  pad_ff   <= 1'b1;
                  final_ff <= 1'b1;
                  state_ff <= ST_LOAD;
               end else if (second_ff) begin
                  // Full block done; the finish pads an empty buffer.
                  finish_ff <= 1'b1;
                  second_ff <= 1'b0;
                  final_ff  <= 1'b1;
                  pos_ff    <= '0;
                  state_ff  <= ST_LOAD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  oidx_ff <= oidx_ff + 3'd1;
                  if (oidx_ff == 3'd7) begin
                     ovalid_ff <= 1'b0;
                     state_ff  <= ST_CLEAR;
                  end
               end
            end
            ST_CLEAR: begin
               finish_ff <= 1'b0;
               pad_ff    <= 1'b0;
               second_ff <= 1'b0;
               final_ff  <= 1'b0;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_digest_word = status.out_word;
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = (oidx_ff == 3'd7);

endmodule
`default_nettype wire

FILE: hdl/sha256_stream_hasher.sv
// Streaming SHA-256 hasher: one message byte per request, eight digest words per finish.
// An absorb is taken while idle; the 64th byte of a block starts a block pass:
// schedule loading over the single buffer read port, 64 rounds, then a fold.
// A finish takes one or two such block passes, then 8 output words and a clear step.
// No new request is taken while a block pass, the output or the clear is under way.
// Synchronous reset restores the initial hash values and empties the buffer.
`default_nettype none
module sha256_stream_hasher
   import sha256_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   sha256_stream_if.sink   req,
   sha256_stream_if.source rsp
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [31:0]   word_l;
   logic [2:0]    idx_l;
   logic          last_l;

   sha256_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_opcode     (req.payload.opcode),
      .req_data_byte  (req.payload.data_byte),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_digest_word(word_l),
      .rsp_word_index (idx_l),
      .rsp_last_word  (last_l),
      .cmd            (cmd),
      .status         (status)
   );

   sha256_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .status(status)
   );

   assign rsp.payload.digest_word = word_l;
   assign rsp.payload.word_index  = idx_l;
   assign rsp.payload.last_word   = last_l;

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.last_word |-> rsp.payload.word_index == 3'd7)
      else $error("last word flag off index seven");
   a_no_req_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while digest pending");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp.payload.last_word |=>
         rsp.payload.word_index == $past(rsp.payload.word_index) + 3'd1)
      else $error("digest word index skipped");

endmodule
`default_nettype wire

FILE: sim/sha256_stream_hasher_tb_pkg.sv
// Request and response layouts for the SHA-256 hasher testbench.
// Depends on sha256_pkg for the opcode and word types.
package sha256_stream_hasher_tb_pkg;
   import sha256_pkg::*;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } rsp_item_type;

endpackage

FILE: sim/sha256_stream_hasher_checker.sv
// Digest checker: follows the request stream, computes SHA-256 and compares responses.
// Depends on sha256_pkg, sha256_stream_if and sha256_stream_hasher_tb_pkg.
module sha256_stream_hasher_checker
   import sha256_pkg::*;
   import sha256_stream_hasher_tb_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   sha256_stream_if   req_mon,
   sha256_stream_if   rsp_mon,
   output int         pending_words,
   output int         error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   word_type     chain_h [8];
   logic [7:0]   block_buf [64];
   logic [5:0]   fill;
   logic [63:0]  bit_total;
   rsp_item_type digest_queue [$];

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic clear_hash();
      for (int i = 0; i < 8; i++) chain_h[i] = InitH[i];
      fill = '0;
      bit_total = '0;
   endtask

   task automatic compress_block();
      word_type w [64];
      word_type v [8];
      word_type t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = chain_h[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] += v[i];
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      block_buf[fill] = b;
      bit_total += 64'd8;
      fill = fill + 6'd1;
      if (fill == 6'd0) compress_block();
   endtask

   task automatic finish_digest();
      int pos;
      rsp_item_type r;
      pos = fill;
      block_buf[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
         for (int i = pos; i < 64; i++) block_buf[i] = 8'h00;
         compress_block();
         pos = 0;
      end
      for (int i = pos; i < 56; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[56+i] = bit_total[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         r.digest_word = chain_h[i];
         r.word_index  = 3'(i);
         r.last_word   = (i == 7);
         digest_queue.push_back(r);
      end
      clear_hash();
   endtask

   always @(posedge clock) begin
      req_item_type q;
      rsp_item_type got, want;
      if (reset) begin
         clear_hash();
         digest_queue.delete();
         error_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            q = req_mon.payload;
            case (q.opcode)
               OP_ABSORB: absorb_byte(q.data_byte);
               OP_ABSORB_FINISH: begin
                  absorb_byte(q.data_byte);
                  finish_digest();
               end
               OP_FINISH: finish_digest();
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (digest_queue.size() == 0) begin
               if (error_count < 10)
                  $display("%t: response with no digest pending: %h", $realtime, got);
               error_count <= error_count + 1;
            end else begin
               want = digest_queue.pop_front();
               if (got !== want) begin
                  if (error_count < 10)
                     $display("%t: digest word mismatch: expected word %h index %0d last %b, got word %h index %0d last %b",
                              $realtime, want.digest_word, want.word_index, want.last_word,
                              got.digest_word, got.word_index, got.last_word);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      pending_words <= digest_queue.size();
   end

   initial begin
      pending_words = 0;
      error_count = 0;
   end
endmodule

FILE: sim/sha256_stream_hasher_tb.sv
// Testbench top: drives byte requests and finishes into the hasher and gives the verdict.
// Depends on sha256_pkg, sha256_stream_if, the tb package and the checker.
module sha256_stream_hasher_tb;
   import sha256_pkg::*;
   import sha256_stream_hasher_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   pending_words;
   int   error_count;
   int   sent_count;
   int   burst_left;
   int   cycle_count;

   sha256_stream_if #(.payload_type(req_item_type)) req_if (clock);
   sha256_stream_if #(.payload_type(rsp_item_type)) rsp_if (clock);

   sha256_stream_hasher DUT (.clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if));

   sha256_stream_hasher_checker digest_checker (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .pending_words(pending_words), .error_count(error_count));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case (cycle_count[10:9])
         2'd0: rsp_if.ready <= 1'b1;
         2'd1: rsp_if.ready <= ($urandom_range(3, 0) != 0);
         2'd2: rsp_if.ready <= ($urandom_range(3, 0) == 0);
         default: rsp_if.ready <= (cycle_count[3:0] < 4'd9);
      endcase
   end

   task automatic send_request(input opcode_type op, input logic [7:0] b);
      req_item_type r;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(20, 1);
      end
      burst_left--;
      r.opcode = op;
      r.data_byte = b;
      req_if.payload <= r;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   task automatic send_message(input int len, input bit tail_byte, input bit fixed, input logic [7:0] fill_val);
      for (int i = 0; i < len; i++)
         send_request(OP_ABSORB, fixed ? fill_val : 8'($urandom));
      if (tail_byte) send_request(OP_ABSORB_FINISH, fixed ? fill_val : 8'($urandom));
      else send_request(OP_FINISH, 8'($urandom));
   endtask

   initial begin
      int len;
      cycle_count = 0;
      sent_count = 0;
      burst_left = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(OP_FINISH, 8'hFF);
      send_request(OP_ABSORB_FINISH, 8'h00);
      send_request(OP_ABSORB_FINISH, 8'hFF);
      send_request(OP_NONE, 8'hA5);
      send_request(OP_ABSORB, 8'h61);
      send_request(OP_NONE, 8'h5A);
      send_request(OP_ABSORB, 8'h62);
      send_request(OP_ABSORB_FINISH, 8'h63);
      send_message(4, 1'b0, 1'b1, 8'h55);
      send_message(2, 1'b1, 1'b1, 8'hAA);
      while (sent_count < 460) begin
         case ($urandom_range(5, 0))
            0: len = $urandom_range(8, 0);
            1: len = $urandom_range(57, 53);
            2: len = $urandom_range(65, 61);
            3: len = $urandom_range(130, 0);
            default: len = $urandom_range(40, 0);
         endcase
         if (len > 460 - sent_count) len = 460 - sent_count;
         if ($urandom_range(9, 0) == 0) send_request(OP_NONE, 8'($urandom));
         send_message(len, $urandom_range(1, 0), $urandom_range(7, 0) == 0, 8'($urandom));
      end
      req_if.valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("sha256_stream_hasher_tb: done, clean");
      else
         $display("sha256_stream_hasher_tb: done, errors");
      $finish;
   end

   initial begin
      #10000000;
      $display("sha256_stream_hasher_tb: done, errors");
      $finish;
   end
endmodule
